/* sv/pof_pkg.sv */
// Shared types, constants and helper functions for the pose offset fusion block.
package pof_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int CW = 40;  // CORDIC x/y datapath width
  localparam int ZW = 36;  // CORDIC angle width, 1 rad = 2^30
  localparam int MW = 32;  // multiplier operand width
  localparam int AW = 66;  // accumulator width

  localparam logic signed [17:0] PI_Q     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;

  localparam logic signed [ZW-1:0] PI_U      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_U = 36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 40'sd652032874;

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cordic_mode_e;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic    en;
    mac_op_e op;
  } mac_ctl_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // one correction step is enough for anything within +-3 pi
  function automatic logic signed [15:0] wrap_yaw(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > PI_Q) begin
      r = a - TWO_PI_Q;
    end else if (a < -PI_Q) begin
      r = a + TWO_PI_Q;
    end
    return r[15:0];
  endfunction

endpackage

/* sv/pof_cordic.sv */
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
module pof_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pof_pkg::cordic_ctl_t                ctl_i,
  input  logic signed [pof_pkg::CW-1:0]       x0_i,
  input  logic signed [pof_pkg::CW-1:0]       y0_i,
  input  logic signed [pof_pkg::ZW-1:0]       z0_i,
  output logic signed [pof_pkg::CW-1:0]       x_o,
  output logic signed [pof_pkg::CW-1:0]       y_o,
  output logic signed [pof_pkg::ZW-1:0]       z_o,
  output logic                                done_o
);
  import pof_pkg::*;

  localparam int IW = $clog2(STEPS + 1);

  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic signed [ZW-1:0] z_q, at;
  logic [IW-1:0]        it_q;
  logic                 busy_q, done_q, pos;
  cordic_mode_e         mode_q;

  always_comb begin
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    at = signed'({{(ZW-32){1'b0}}, atan_lut(5'(it_q))});
    // direction: vectoring drives y to zero, rotation drives z to zero
    if (mode_q == CM_VECTOR) begin
      pos = !(!y_q[CW-1] && (|y_q));
    end else begin
      pos = !z_q[ZW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      it_q   <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= CM_ROTATE;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        x_q    <= x0_i;
        y_q    <= y0_i;
        z_q    <= z0_i;
        mode_q <= ctl_i.mode;
        it_q   <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (pos) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        it_q <= it_q + 1'b1;
        if (it_q == IW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

/* sv/pof_mac.sv */
// Shared signed multiplier with registered product and accumulator.
module pof_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pof_pkg::mac_ctl_t             ctl_i,
  input  logic signed [pof_pkg::MW-1:0] a_i,
  input  logic signed [pof_pkg::MW-1:0] b_i,
  output logic signed [pof_pkg::AW-1:0] acc_o
);
  import pof_pkg::*;

  logic signed [2*MW-1:0] prod_q;
  logic signed [AW-1:0]   acc_q;
  mac_ctl_t               ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '{en: 1'b0, op: MAC_LOAD};
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      ctl_q  <= ctl_i;
      prod_q <= a_i * b_i;
      if (ctl_q.en) begin
        case (ctl_q.op)
          MAC_LOAD: acc_q <= AW'(prod_q);
          MAC_ADD:  acc_q <= acc_q + AW'(prod_q);
          MAC_SUB:  acc_q <= acc_q - AW'(prod_q);
          default:  acc_q <= acc_q;
        endcase
      end
    end
  end

  assign acc_o = acc_q;

endmodule

/* sv/pose_offset_fusion.sv */
// Top level: pose offset fusion sequencer around a shared CORDIC unit and multiplier.
// Takes one pose request at a time; in_stall_o stays high until the request's work is
// done. One CORDIC unit runs a vectoring pass for the heading (skipped for a degenerate
// quaternion), a rotation pass for the offset sine/cosine (skipped for odometry with no
// offset and for a marker before odometry) and a rotation pass for the half-heading
// quaternion; one 32x32 multiplier forms the twelve quaternion products and the four
// position products in turn. A finished result sits in the output register while the
// next request is already accepted.
module pose_offset_fusion #(
  parameter int unsigned CORDIC_STEPS = pof_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic [31:0]        stamp_tag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] out_quat_z_o,
  output logic signed [15:0] out_quat_w_o,
  output logic [31:0]        out_stamp_tag_o
);
  import pof_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QMUL, ST_YAW, ST_VEC, ST_DECIDE, ST_SC_GO, ST_SC_WAIT,
    ST_PMUL, ST_PFIN, ST_HALF_GO, ST_HALF_WAIT, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    GRP_NONE, GRP_X, GRP_D, GRP_G, GRP_Y, GRP_A, GRP_B
  } grp_e;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [15:0]   r;
    t = (v + CW'(32768)) >>> 16;
    if (t > CW'(16384)) begin
      r = 16'sd16384;
    end else if (t < -CW'(16384)) begin
      r = -16'sd16384;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  state_e state_q;
  logic [3:0] step_q;

  // request registers
  logic               op_q;
  logic signed [31:0] px_q, py_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic [31:0]        tag_q;

  // working registers
  logic signed [35:0] sx_q, sd_q, sg_q, sy_q, ra_q, rb_q;
  logic signed [15:0] yaw_q, ang_q, ox_yaw_q;
  logic signed [31:0] c_q, s_q, ox_q, oy_q;
  logic               neg_q;
  grp_e               grp_d1_q, grp_d2_q;

  // block state
  logic               odom_seen_q, offset_valid_q;
  logic signed [31:0] last_x_q, last_y_q, shift_x_q, shift_y_q;
  logic signed [15:0] last_yaw_q, shift_yaw_q;

  // outputs
  logic               out_valid_q;
  logic signed [31:0] wx_q, wy_q;
  logic signed [15:0] wyaw_q, wqz_q, wqw_q;
  logic [31:0]        wtag_q;

  // shared units
  cordic_ctl_t          cor_ctl;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z0, cor_z;
  logic                 cor_done;
  mac_ctl_t             mac_ctl;
  logic signed [MW-1:0] mac_a, mac_b;
  logic signed [AW-1:0] acc, acc_rnd;
  grp_e                 issue_grp;

  logic [1:0]           asel, bsel;
  logic signed [CW-1:0] vx, vy;
  logic signed [36:0]   g_abs;
  logic                 degenerate;
  logic signed [ZW-1:0] ang_u;
  logic signed [31:0]   pu, pv;

  pof_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cor_ctl), .x0_i(cor_x0), .y0_i(cor_y0), .z0_i(cor_z0),
    .x_o(cor_x), .y_o(cor_y), .z_o(cor_z), .done_o(cor_done)
  );

  pof_mac u_mac (
    .clk_i, .rst_ni, .ctl_i(mac_ctl), .a_i(mac_a), .b_i(mac_b), .acc_o(acc)
  );

  function automatic logic signed [MW-1:0] qsel(input logic [1:0] sel,
      input logic signed [15:0] x, input logic signed [15:0] y,
      input logic signed [15:0] z, input logic signed [15:0] w);
    logic signed [15:0] r;
    case (sel)
      2'd0:    r = x;
      2'd1:    r = y;
      2'd2:    r = z;
      default: r = w;
    endcase
    return MW'(r);
  endfunction

  assign acc_rnd = (acc + AW'(64'd536870912)) >>> 30;

  // multiplier schedule
  always_comb begin
    mac_ctl   = '{en: 1'b0, op: MAC_LOAD};
    issue_grp = GRP_NONE;
    asel      = 2'd0;
    bsel      = 2'd0;
    mac_a     = '0;
    mac_b     = '0;
    pu        = op_q ? last_x_q : px_q;
    pv        = op_q ? last_y_q : py_q;
    if (state_q == ST_QMUL && step_q < 4'd12) begin
      mac_ctl.en = 1'b1;
      case (step_q)
        // X = ww + xx - yy - zz
        4'd0:  begin asel = 2'd3; bsel = 2'd3; mac_ctl.op = MAC_LOAD; end
        4'd1:  begin asel = 2'd0; bsel = 2'd0; mac_ctl.op = MAC_ADD;  end
        4'd2:  begin asel = 2'd1; bsel = 2'd1; mac_ctl.op = MAC_SUB;  end
        4'd3:  begin asel = 2'd2; bsel = 2'd2; mac_ctl.op = MAC_SUB; issue_grp = GRP_X; end
        // D = ww + xx + yy + zz
        4'd4:  begin asel = 2'd3; bsel = 2'd3; mac_ctl.op = MAC_LOAD; end
        4'd5:  begin asel = 2'd0; bsel = 2'd0; mac_ctl.op = MAC_ADD;  end
        4'd6:  begin asel = 2'd1; bsel = 2'd1; mac_ctl.op = MAC_ADD;  end
        4'd7:  begin asel = 2'd2; bsel = 2'd2; mac_ctl.op = MAC_ADD; issue_grp = GRP_D; end
        // G = xz - wy
        4'd8:  begin asel = 2'd0; bsel = 2'd2; mac_ctl.op = MAC_LOAD; end
        4'd9:  begin asel = 2'd3; bsel = 2'd1; mac_ctl.op = MAC_SUB; issue_grp = GRP_G; end
        // Y = xy + wz
        4'd10: begin asel = 2'd0; bsel = 2'd1; mac_ctl.op = MAC_LOAD; end
        default: begin
          asel = 2'd3; bsel = 2'd2; mac_ctl.op = MAC_ADD; issue_grp = GRP_Y;
        end
      endcase
      mac_a = qsel(asel, qx_q, qy_q, qz_q, qw_q);
      mac_b = qsel(bsel, qx_q, qy_q, qz_q, qw_q);
    end else if (state_q == ST_PMUL && step_q < 4'd4) begin
      mac_ctl.en = 1'b1;
      case (step_q)
        4'd0:    begin mac_a = c_q; mac_b = pu; mac_ctl.op = MAC_LOAD; end
        4'd1:    begin mac_a = s_q; mac_b = pv; mac_ctl.op = MAC_SUB; issue_grp = GRP_A; end
        4'd2:    begin mac_a = s_q; mac_b = pu; mac_ctl.op = MAC_LOAD; end
        default: begin mac_a = c_q; mac_b = pv; mac_ctl.op = MAC_ADD; issue_grp = GRP_B; end
      endcase
    end
  end

  // CORDIC launch
  always_comb begin
    vx         = CW'(sx_q);
    vy         = CW'(sy_q) <<< 1;
    g_abs      = sg_q[35] ? -(37'(sg_q) <<< 1) : (37'(sg_q) <<< 1);
    degenerate = (g_abs >= 37'(sd_q)) || (vx == '0 && vy == '0);
    ang_u      = ZW'(ang_q) <<< 17;
    cor_ctl    = '{start: 1'b0, mode: CM_ROTATE};
    cor_x0     = CORDIC_GAIN;
    cor_y0     = '0;
    cor_z0     = '0;
    case (state_q)
      ST_YAW: begin
        cor_ctl = '{start: !degenerate, mode: CM_VECTOR};
        if (vx[CW-1]) begin
          if (!vy[CW-1]) begin
            cor_x0 = vy; cor_y0 = -vx; cor_z0 = HALF_PI_U;
          end else begin
            cor_x0 = -vy; cor_y0 = vx; cor_z0 = -HALF_PI_U;
          end
        end else begin
          cor_x0 = vx; cor_y0 = vy;
        end
      end
      ST_SC_GO: begin
        cor_ctl.start = 1'b1;
        if (ang_u > HALF_PI_U) begin
          cor_z0 = ang_u - PI_U;
        end else if (ang_u < -HALF_PI_U) begin
          cor_z0 = ang_u + PI_U;
        end else begin
          cor_z0 = ang_u;
        end
      end
      ST_HALF_GO: begin
        cor_ctl.start = 1'b1;
        cor_z0 = ZW'(ox_yaw_q) <<< 16;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= '0;
      grp_d1_q       <= GRP_NONE;
      grp_d2_q       <= GRP_NONE;
      odom_seen_q    <= 1'b0;
      offset_valid_q <= 1'b0;
      last_x_q       <= '0;
      last_y_q       <= '0;
      last_yaw_q     <= '0;
      shift_x_q      <= '0;
      shift_y_q      <= '0;
      shift_yaw_q    <= '0;
      out_valid_q    <= 1'b0;
      op_q <= 1'b0; px_q <= '0; py_q <= '0; tag_q <= '0;
      qx_q <= '0; qy_q <= '0; qz_q <= '0; qw_q <= '0;
      sx_q <= '0; sd_q <= '0; sg_q <= '0; sy_q <= '0; ra_q <= '0; rb_q <= '0;
      yaw_q <= '0; ang_q <= '0; ox_yaw_q <= '0; c_q <= '0; s_q <= '0;
      ox_q <= '0; oy_q <= '0; neg_q <= 1'b0;
      wx_q <= '0; wy_q <= '0; wyaw_q <= '0; wqz_q <= '0; wqw_q <= '0; wtag_q <= '0;
    end else begin
      grp_d1_q <= issue_grp;
      grp_d2_q <= grp_d1_q;
      case (grp_d2_q)
        GRP_X:   sx_q <= acc[35:0];
        GRP_D:   sd_q <= acc[35:0];
        GRP_G:   sg_q <= acc[35:0];
        GRP_Y:   sy_q <= acc[35:0];
        GRP_A:   ra_q <= acc_rnd[35:0];
        GRP_B:   rb_q <= acc_rnd[35:0];
        default: ;
      endcase

      // in ST_OUT the output register is reloaded instead
      if (out_valid_q && !out_stall_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q  <= operation_i;
            px_q  <= pos_x_i;
            py_q  <= pos_y_i;
            qx_q  <= quat_x_i;
            qy_q  <= quat_y_i;
            qz_q  <= quat_z_i;
            qw_q  <= quat_w_i;
            tag_q <= stamp_tag_i;
            step_q  <= '0;
            state_q <= ST_QMUL;
          end
        end
        ST_QMUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd13) begin
            state_q <= ST_YAW;
          end
        end
        ST_YAW: begin
          if (degenerate) begin
            yaw_q   <= '0;
            state_q <= ST_DECIDE;
          end else begin
            state_q <= ST_VEC;
          end
        end
        ST_VEC: begin
          if (cor_done) begin
            yaw_q   <= wrap_yaw(18'((cor_z + ZW'(65536)) >>> 17));
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          ox_q     <= px_q;
          oy_q     <= py_q;
          ox_yaw_q <= yaw_q;
          if (op_q) begin
            if (!odom_seen_q) begin
              shift_x_q      <= px_q;
              shift_y_q      <= py_q;
              shift_yaw_q    <= yaw_q;
              offset_valid_q <= 1'b1;
              state_q        <= ST_HALF_GO;
            end else begin
              ang_q   <= wrap_yaw(18'(yaw_q) - 18'(last_yaw_q));
              state_q <= ST_SC_GO;
            end
          end else begin
            last_x_q    <= px_q;
            last_y_q    <= py_q;
            last_yaw_q  <= yaw_q;
            odom_seen_q <= 1'b1;
            if (offset_valid_q) begin
              ang_q   <= shift_yaw_q;
              state_q <= ST_SC_GO;
            end else begin
              state_q <= ST_HALF_GO;
            end
          end
        end
        ST_SC_GO: begin
          // angles beyond +-pi/2 are folded by pi and the result negated
          neg_q   <= (ang_u > HALF_PI_U) || (ang_u < -HALF_PI_U);
          state_q <= ST_SC_WAIT;
        end
        ST_SC_WAIT: begin
          if (cor_done) begin
            c_q     <= neg_q ? -cor_x[31:0] : cor_x[31:0];
            s_q     <= neg_q ? -cor_y[31:0] : cor_y[31:0];
            step_q  <= '0;
            state_q <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd5) begin
            state_q <= ST_PFIN;
          end
        end
        ST_PFIN: begin
          if (op_q) begin
            shift_x_q      <= sat32(37'(px_q) - 37'(ra_q));
            shift_y_q      <= sat32(37'(py_q) - 37'(rb_q));
            shift_yaw_q    <= ang_q;
            offset_valid_q <= 1'b1;
          end else begin
            ox_q     <= sat32(37'(ra_q) + 37'(shift_x_q));
            oy_q     <= sat32(37'(rb_q) + 37'(shift_y_q));
            ox_yaw_q <= wrap_yaw(18'(yaw_q) + 18'(shift_yaw_q));
          end
          state_q <= ST_HALF_GO;
        end
        ST_HALF_GO: begin
          state_q <= ST_HALF_WAIT;
        end
        ST_HALF_WAIT: begin
          if (cor_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            wx_q        <= ox_q;
            wy_q        <= oy_q;
            wyaw_q      <= ox_yaw_q;
            wqz_q       <= q14(cor_y);
            wqw_q       <= q14(cor_x);
            wtag_q      <= tag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign world_x_o       = wx_q;
  assign world_y_o       = wy_q;
  assign heading_o       = wyaw_q;
  assign out_quat_z_o    = wqz_q;
  assign out_quat_w_o    = wqw_q;
  assign out_stamp_tag_o = wtag_q;

endmodule

/* dv/pose_offset_fusion_checker.sv */
// Checker for pose_offset_fusion: predicts each world pose and compares the results.
module pose_offset_fusion_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               operation_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic [31:0]        stamp_tag_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] out_quat_z_i,
  input  logic signed [15:0] out_quat_w_i,
  input  logic [31:0]        out_stamp_tag_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int STEPS = pof_pkg::CORDIC_STEPS_DEF;
  localparam int PIQ = 25736;
  localparam longint GAIN = 64'sd652032874;
  localparam longint PIU = 64'sd3373259426;
  localparam longint HPIU = 64'sd1686629713;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [15:0] yaw;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [31:0]        tag;
  } world_pose_t;

  world_pose_t pose_q[$];
  int fails = 0;

  // fused-frame state
  bit odom_seen, offset_valid;
  int odom_x, odom_y, odom_yaw, shift_x, shift_y, shift_yaw;

  assign fail_count_o = fails;
  assign pending_o = pose_q.size();

  function automatic longint atan_step(int i);
    return longint'(pof_pkg::atan_lut(i[4:0]));
  endfunction

  function automatic int wrap_angle(int a);
    int r;
    r = a;
    while (r > PIQ) r -= 2 * PIQ;
    while (r < -PIQ) r += 2 * PIQ;
    return r;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int heading_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HPIU;
      end else begin
        t = x; x = -y; y = t; z = -HPIU;
      end
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return wrap_angle(int'((z + 65536) >>> 17));
  endfunction

  task automatic rotate_unit(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN;
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = x;
    s = y;
  endtask

  task automatic heading_sincos(int yaw, output longint c, output longint s);
    longint a;
    bit neg;
    a = longint'(yaw) * 131072;
    neg = 0;
    if (a > HPIU) begin
      a -= PIU; neg = 1;
    end else if (a < -HPIU) begin
      a += PIU; neg = 1;
    end
    rotate_unit(a, c, s);
    if (neg) begin
      c = -c; s = -s;
    end
  endtask

  function automatic int quat_heading(longint x, longint y, longint z, longint w);
    longint d, g;
    d = x * x + y * y + z * z + w * w;
    g = 2 * (x * z - w * y);
    if (g < 0) g = -g;
    if (g >= d) return 0;  // gimbal lock or null quaternion
    return heading_atan2(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
  endfunction

  function automatic longint round30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    v = (v + 32768) >>> 16;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  task automatic fuse_request();
    int px, py, yaw, ox, oy, oyaw;
    longint c, s, hc, hs;
    world_pose_t p;
    px = pos_x_i;
    py = pos_y_i;
    yaw = quat_heading(quat_x_i, quat_y_i, quat_z_i, quat_w_i);
    ox = px; oy = py; oyaw = yaw;
    if (operation_i) begin
      if (!odom_seen) begin
        shift_x = px; shift_y = py; shift_yaw = yaw;
      end else begin
        shift_yaw = wrap_angle(yaw - odom_yaw);
        heading_sincos(shift_yaw, c, s);
        shift_x = sat32(longint'(px) - round30(c * odom_x - s * odom_y));
        shift_y = sat32(longint'(py) - round30(s * odom_x + c * odom_y));
      end
      offset_valid = 1;
    end else begin
      odom_x = px; odom_y = py; odom_yaw = yaw;
      odom_seen = 1;
      if (offset_valid) begin
        heading_sincos(shift_yaw, c, s);
        ox = sat32(round30(c * px - s * py) + shift_x);
        oy = sat32(round30(s * px + c * py) + shift_y);
        oyaw = wrap_angle(yaw + shift_yaw);
      end
    end
    rotate_unit(longint'(oyaw) * 65536, hc, hs);
    p.wx = ox;
    p.wy = oy;
    p.yaw = oyaw[15:0];
    p.qz = to_q14(hs);
    p.qw = to_q14(hc);
    p.tag = stamp_tag_i;
    pose_q.push_back(p);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    world_pose_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) fuse_request();
      if (out_valid_i && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected result, tag", out_stamp_tag_i, 0);
        end else begin
          e = pose_q.pop_front();
          if (world_x_i !== e.wx) report_mismatch("world_x", world_x_i, e.wx);
          if (world_y_i !== e.wy) report_mismatch("world_y", world_y_i, e.wy);
          if (heading_i !== e.yaw) report_mismatch("heading", heading_i, e.yaw);
          if (out_quat_z_i !== e.qz) report_mismatch("out_quat_z", out_quat_z_i, e.qz);
          if (out_quat_w_i !== e.qw) report_mismatch("out_quat_w", out_quat_w_i, e.qw);
          if (out_stamp_tag_i !== e.tag)
            report_mismatch("out_stamp_tag", out_stamp_tag_i, e.tag);
        end
      end
    end
  end

endmodule

/* dv/pose_offset_fusion_tb.sv */
// Testbench top for pose_offset_fusion: stimulus, receiver stalls, watchdog and verdict.
module pose_offset_fusion_tb;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic               operation = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0;
  logic signed [15:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
  logic [31:0]        stamp_tag = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] world_x, world_y;
  logic signed [15:0] heading, out_quat_z, out_quat_w;
  logic [31:0]        out_stamp_tag;
  int                 fail_count, pending;
  bit                 hold_off = 0;
  int                 idle_cycles = 0;
  int                 tag_seq = 0;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1430;

  pose_offset_fusion dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .operation_i(operation),
    .pos_x_i(pos_x), .pos_y_i(pos_y),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .stamp_tag_i(stamp_tag),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .world_x_o(world_x), .world_y_o(world_y), .heading_o(heading),
    .out_quat_z_o(out_quat_z), .out_quat_w_o(out_quat_w), .out_stamp_tag_o(out_stamp_tag)
  );

  pose_offset_fusion_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .operation_i(operation),
    .pos_x_i(pos_x), .pos_y_i(pos_y),
    .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z), .quat_w_i(quat_w),
    .stamp_tag_i(stamp_tag),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .world_x_i(world_x), .world_y_i(world_y), .heading_i(heading),
    .out_quat_z_i(out_quat_z), .out_quat_w_i(out_quat_w),
    .out_stamp_tag_i(out_stamp_tag),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // drive one request and hold it until accepted
  task automatic send_pose(logic op, logic [31:0] px, logic [31:0] py,
                           logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz, logic [15:0] qw, int gap);
    bit took;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    pos_x <= px;
    pos_y <= py;
    quat_x <= qx;
    quat_y <= qy;
    quat_z <= qz;
    quat_w <= qw;
    stamp_tag <= (tag_seq % 3 == 0) ? $urandom() : ~$urandom();
    tag_seq++;
    // stall is sampled mid-cycle, as it stands at the coming edge
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
                                     : 32'h80000000 + $urandom_range(0, 255);
      default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_q();
    return 16'(signed'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic send_random(int gap);
    logic op;
    logic [15:0] qx, qy, qz, qw;
    op = ($urandom_range(0, 5) == 0);
    qz = rand_q();
    qw = rand_q();
    case ($urandom_range(0, 9))
      0: begin
        qx = 16'($urandom()); qy = 16'($urandom());
        qz = 16'($urandom()); qw = 16'($urandom());
      end
      1: begin qx = rand_q(); qy = rand_q(); end
      2: begin qx = 16'd16384; qy = '0; qz = 16'd16384; qw = '0; end
      default: begin qx = '0; qy = '0; end
    endcase
    send_pose(op, rand_pos(), rand_pos(), qx, qy, qz, qw, gap);
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int run;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
        out_stall <= 0;
      end else begin
        run = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: out_stall <= 0;
          1: out_stall <= 1;
          default: out_stall <= ($urandom_range(0, 2) == 0);
        endcase
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int burst, gap;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // marker before any odometry sets the offset itself
    send_pose(1'b1, 32'h00010000, 32'hfffe0000, '0, '0, 16'd11585, 16'd11585, 0);
    send_pose(1'b0, 32'h7fffffff, 32'h7fffffff, '0, '0, 16'd16384, '0, 0);
    send_pose(1'b0, 32'h80000000, 32'h80000000, '0, '0, 16'hc000, '0, 1);
    send_pose(1'b0, 32'h80000000, 32'h7fffffff, '0, '0, '0, 16'd16384, 0);
    send_pose(1'b0, '0, '0, '0, '0, '0, '0, 0);                     // null quaternion
    send_pose(1'b0, 32'h12345678, 32'hedcba987, 16'd16384, '0, 16'd16384, '0, 2);  // gimbal
    send_pose(1'b0, 32'h00050000, 32'h00030000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_pose(1'b0, 32'hffffffff, 32'h00000001, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_pose(1'b1, 32'h7fffffff, 32'h80000000, '0, '0, 16'hc000, 16'd1, 0);
    send_pose(1'b0, 32'h7fffffff, 32'h80000000, '0, '0, 16'd16384, 16'd1, 0);
    send_pose(1'b0, 32'h80000000, 32'h7fffffff, 16'd100, 16'hff00, 16'd16384, 16'hc000, 3);
    send_pose(1'b1, 32'h00000000, 32'h00000000, '0, '0, 16'hc000, 16'hc000, 0);
    send_pose(1'b0, 32'h00100000, 32'hfff00000, '0, '0, 16'd6000, 16'hc200, 0);
    send_pose(1'b1, 32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
    send_pose(1'b0, 32'haaaaaaaa, 32'h55555555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
        gap = (b == 0) ? $urandom_range(0, 60) : (($urandom_range(0, 4) == 0) ? 1 : 0);
        if (n == 400) hold_off = 1;
        if (n == 900) begin
          in_valid <= 0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
        send_random(gap);
      end
    end
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
sv/pof_pkg.sv
sv/pof_cordic.sv
sv/pof_mac.sv
sv/pose_offset_fusion.sv
dv/pose_offset_fusion_checker.sv
dv/pose_offset_fusion_tb.sv
